// ===== sv/dctq_pkg.sv =====
// package: types and constants for the dependency counting task queue
package dctq_pkg;
    localparam int TaskSlots = 16;
    localparam logic [3:0] LimitReset = 4'd11;

    typedef enum logic [1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEP = 2'd1,
        CMD_DISP = 2'd2,
        CMD_CMPL = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_NONE_READY = 3'd1,
        ST_NO_FREE = 3'd2,
        ST_HAS_PARENT = 3'd3,
        ST_LIMIT = 3'd4,
        ST_UNUSED = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_WB,
        S_UNLINK,
        S_PAY,
        S_OUT
    } t_state;
endpackage

// ===== sv/dependency_counting_task_queue.sv =====
// top level: dependency counting task queue with sequenced ring scan
//
// channel    dir  fields
// s_axis     in   tdata = cmd[1:0], payload[65:2], task_slot[69:66], parent_slot[73:70]
// m_axis     out  tdata = status[2:0], out_slot[6:3], out_payload[70:7]
// cfg        in   i_cfg_data = dependency_limit
//
// enqueue and depend: the item is worked in the scan state, then the out state raises result valid
// dispatch: scan, compact and write back one ring entry a cycle;
// passed-over entries go after the rest, and status is none ready when no entry is ready
// complete: parent link walk over all slots, then ring compaction
// synchronous active-low reset clears slot state; no clearing pass
// input is not ready while an item is at work or a result waits
module dependency_counting_task_queue
    import dctq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // cmd, payload, task_slot, parent_slot
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // status, out_slot, out_payload
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);
    localparam int TASK_SLOTS = TaskSlots;
    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);

    t_state r_state, n_state;
    logic [3:0] r_limit;
    logic [TASK_SLOTS-1:0] r_used;
    logic [TASK_SLOTS-1:0] r_has_par;
    logic [SW-1:0] r_par [TASK_SLOTS];
    logic [3:0] r_cnt [TASK_SLOTS];
    logic [SW-1:0] r_ring [TASK_SLOTS];
    logic [63:0] r_pay_mem [TASK_SLOTS];
    logic [SW-1:0] r_front;
    logic [CW-1:0] r_count;

    t_cmd r_cmd;
    logic [63:0] r_pay_in;
    logic [3:0] r_child, r_parent;
    logic [CW-1:0] r_k, r_found;
    logic [SW-1:0] r_sel;
    logic [2:0] r_status;
    logic [3:0] r_oslot;
    logic [63:0] r_opay;
    logic r_ovalid;
    logic [SW-1:0] r_tmp [TASK_SLOTS];
    logic [CW-1:0] r_n;
    logic [63:0] r_pay_rd;

    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {1'b0, r_opay, r_oslot, r_status};

    // lowest free slot within the 4-bit slot field
    logic [SW-1:0] free_idx;
    logic free_ok;
    always_comb begin
        free_idx = '0;
        free_ok = 1'b0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
            if (i < 16 && !r_used[i]) begin
                free_idx = SW'(i);
                free_ok = 1'b1;
            end
        end
    end

    logic [SW-1:0] pos_k;
    logic [SW-1:0] ring_k;
    logic [CW:0] pos_sum;
    always_comb begin
        pos_sum = (CW+1)'(r_front) + (CW+1)'(r_k);
        if (pos_sum >= (CW+1)'(TASK_SLOTS)) pos_sum = pos_sum - (CW+1)'(TASK_SLOTS);
        pos_k = pos_sum[SW-1:0];
        ring_k = r_ring[pos_k];
    end

    logic c_valid, p_valid;
    assign c_valid = (32'(r_child) < TASK_SLOTS) && r_used[r_child[SW-1:0]];
    assign p_valid = (32'(r_parent) < TASK_SLOTS) && r_used[r_parent[SW-1:0]];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (acc) n_state = S_SCAN;
            S_SCAN: begin
                unique case (r_cmd)
                    CMD_ENQ, CMD_DEP: n_state = S_OUT;
                    CMD_DISP: if (r_k == r_count) n_state = S_OUT;
                        else if (r_cnt[ring_k] == 4'd0) n_state = S_SHIFT;
                    CMD_CMPL: n_state = c_valid ? S_UNLINK : S_OUT;
                    default: n_state = S_OUT;
                endcase
            end
            S_SHIFT: if (r_k == r_count) n_state = (r_cmd == CMD_DISP) ? S_WB : S_OUT;
            S_WB: if (r_n == r_found) n_state = S_PAY;
            S_UNLINK: if (r_k == CW'(TASK_SLOTS - 1)) n_state = S_SHIFT;
            S_PAY: n_state = S_OUT;
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= LimitReset;
            r_used <= '0;
            r_has_par <= '0;
            r_front <= '0;
            r_count <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < TASK_SLOTS; i++) r_cnt[i] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_limit <= i_cfg_data;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (acc) begin
                    r_cmd <= t_cmd'(s_axis_tdata[1:0]);
                    r_pay_in <= s_axis_tdata[65:2];
                    r_child <= s_axis_tdata[69:66];
                    r_parent <= s_axis_tdata[73:70];
                    r_k <= '0;
                    r_n <= '0;
                    r_status <= ST_OK;
                    r_oslot <= '0;
                    r_opay <= '0;
                end
                S_SCAN: begin
                    unique case (r_cmd)
                        CMD_ENQ: begin
                            if (!free_ok || r_count >= CW'(TASK_SLOTS)) begin
                                r_status <= ST_NO_FREE;
                            end else begin
                                r_used[free_idx] <= 1'b1;
                                r_cnt[free_idx] <= '0;
                                r_has_par[free_idx] <= 1'b0;
                                r_front <= (r_front == '0) ? SW'(TASK_SLOTS - 1)
                                                           : r_front - SW'(1);
                                r_ring[(r_front == '0) ? SW'(TASK_SLOTS - 1)
                                                       : r_front - SW'(1)] <= free_idx;
                                r_count <= r_count + CW'(1);
                                r_oslot <= 4'(free_idx);
                            end
                        end
                        CMD_DEP: begin
                            if (!c_valid || !p_valid) r_status <= ST_UNUSED;
                            else if (r_has_par[r_child[SW-1:0]]) r_status <= ST_HAS_PARENT;
                            else if (r_cnt[r_parent[SW-1:0]] >= r_limit)
                                r_status <= ST_LIMIT;
                            else begin
                                r_has_par[r_child[SW-1:0]] <= 1'b1;
                                r_par[r_child[SW-1:0]] <= r_parent[SW-1:0];
                                r_cnt[r_parent[SW-1:0]] <= r_cnt[r_parent[SW-1:0]] + 4'd1;
                            end
                        end
                        CMD_DISP: begin
                            if (r_k == r_count) begin
                                r_status <= ST_NONE_READY;
                            end else if (r_cnt[ring_k] == 4'd0) begin
                                r_sel <= ring_k;
                                r_found <= r_k;
                                r_k <= '0;
                            end else begin
                                r_tmp[r_k[SW-1:0]] <= ring_k;
                                r_k <= r_k + CW'(1);
                            end
                        end
                        default: begin
                            if (!c_valid) begin
                                r_status <= ST_UNUSED;
                            end else begin
                                if (r_has_par[r_child[SW-1:0]] &&
                                    r_cnt[r_par[r_child[SW-1:0]]] != 4'd0)
                                    r_cnt[r_par[r_child[SW-1:0]]] <=
                                        r_cnt[r_par[r_child[SW-1:0]]] - 4'd1;
                                r_has_par[r_child[SW-1:0]] <= 1'b0;
                                r_used[r_child[SW-1:0]] <= 1'b0;
                                r_k <= '0;
                                r_found <= '0;
                            end
                        end
                    endcase
                end
                S_UNLINK: begin
                    if (r_par[r_k[SW-1:0]] == r_child[SW-1:0])
                        r_has_par[r_k[SW-1:0]] <= 1'b0;
                    r_cnt[r_child[SW-1:0]] <= '0;
                    r_k <= (r_k == CW'(TASK_SLOTS - 1)) ? '0 : r_k + CW'(1);
                end
                S_SHIFT: begin
                    if (r_cmd == CMD_DISP) begin
                        // skip the chosen entry, move the later ones up by one
                        if (r_k == r_count) begin
                            r_count <= r_count - CW'(1);
                            r_front <= pos_sum[SW-1:0] - SW'(r_count - r_found);
                            r_k <= r_count - CW'(1) - r_found;
                        end else if (r_k > r_found) begin
                            r_ring[pos_k - SW'(1)] <= ring_k;
                            r_k <= r_k + CW'(1);
                        end else begin
                            r_k <= r_k + CW'(1);
                        end
                    end else begin
                        // complete: drop the slot from the order, close the gap
                        if (r_k == r_count) begin
                            if (r_n != '0) r_count <= r_count - CW'(1);
                        end else begin
                            if (r_n != '0) r_ring[pos_k - SW'(1)] <= ring_k;
                            else if (ring_k == r_child[SW-1:0]) r_n <= CW'(1);
                            r_k <= r_k + CW'(1);
                        end
                    end
                end
                S_WB: begin
                    // passed-over entries go after the rest
                    if (r_n != r_found) begin
                        r_ring[pos_k] <= r_tmp[r_n[SW-1:0]];
                        r_k <= r_k + CW'(1);
                        r_n <= r_n + CW'(1);
                    end
                end
                S_PAY: begin
                    r_oslot <= 4'(r_sel);
                    r_opay <= r_pay_rd;
                end
                S_OUT: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && r_cmd == CMD_ENQ && free_ok && r_count < CW'(TASK_SLOTS))
            r_pay_mem[free_idx] <= r_pay_in;
        r_pay_rd <= r_pay_mem[r_sel];
    end

    property p_no_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
        !(r_ovalid && s_axis_tready);
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while result waits");

    property p_count_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TASK_SLOTS);
    endproperty
    a_count: assert property (p_count_range) else $error("ring count overflow");

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata);
    endproperty
    a_hold: assert property (p_hold) else $error("result changed while stalled");

    property p_out_after_work;
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == S_OUT;
    endproperty
    a_out: assert property (p_out_after_work) else $error("result without work");
endmodule

// ===== sim/dependency_counting_task_queue_tb.sv =====
// testbench: random and directed command streams checked against a behavioral predictor
`timescale 1ns / 1ps
module dependency_counting_task_queue_tb
    import dctq_pkg::*;
();

    typedef struct packed {
        logic [3:0]  parent_slot;
        logic [3:0]  task_slot;
        logic [63:0] payload;
        t_cmd        cmd;
    } t_cmd_item;

    typedef struct packed {
        logic [63:0] out_payload;
        logic [3:0]  out_slot;
        t_status     status;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data = '0;

    dependency_counting_task_queue u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [63:0] pay_mem [16];
    logic [3:0]  child_cnt [16];
    logic [4:0]  parent_of [16];
    logic [15:0] busy;
    logic [3:0]  ring [16];
    logic [3:0]  front;
    int          count;
    logic [3:0]  dep_limit;

    t_cmd_item   cmd_queue[$];
    t_result     expected_results[$];
    int          errors = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    longint      cycles = 0;
    logic [3:0]  cfg_value;
    int          cfg_req = 0;
    int          cfg_done = 0;

    function automatic t_result predict(t_cmd_item it);
        t_result r;
        int found;
        int s;
        logic [3:0] tmp [16];
        int n;
        r = '0;
        r.status = ST_OK;
        case (it.cmd)
            CMD_ENQ: begin
                s = -1;
                for (int i = 0; i < 16; i++)
                    if (s < 0 && !busy[i]) s = i;
                if (s < 0 || count >= 16) begin
                    r.status = ST_NO_FREE;
                end else begin
                    busy[s] = 1'b1;
                    pay_mem[s] = it.payload;
                    child_cnt[s] = '0;
                    parent_of[s] = 5'h10;
                    front = front - 4'd1;
                    ring[front] = s[3:0];
                    count++;
                    r.out_slot = s[3:0];
                end
            end
            CMD_DEP: begin
                if (!busy[it.task_slot] || !busy[it.parent_slot]) r.status = ST_UNUSED;
                else if (parent_of[it.task_slot] != 5'h10) r.status = ST_HAS_PARENT;
                else if (child_cnt[it.parent_slot] >= dep_limit) r.status = ST_LIMIT;
                else begin
                    parent_of[it.task_slot] = {1'b0, it.parent_slot};
                    child_cnt[it.parent_slot]++;
                end
            end
            CMD_DISP: begin
                found = -1;
                for (int k = 0; k < count; k++)
                    if (found < 0 && child_cnt[ring[front + k[3:0]]] == 0) found = k;
                if (found < 0) begin
                    r.status = ST_NONE_READY;
                end else begin
                    s = int'(ring[front + found[3:0]]);
                    n = 0;
                    for (int k = found + 1; k < count; k++) tmp[n++] = ring[front + k[3:0]];
                    for (int k = 0; k < found; k++) tmp[n++] = ring[front + k[3:0]];
                    for (int k = 0; k < n; k++) ring[front + k[3:0]] = tmp[k];
                    count = n;
                    r.out_slot = s[3:0];
                    r.out_payload = pay_mem[s];
                end
            end
            default: begin
                if (!busy[it.task_slot]) begin
                    r.status = ST_UNUSED;
                end else begin
                    if (parent_of[it.task_slot] != 5'h10
                            && child_cnt[parent_of[it.task_slot][3:0]] > 0)
                        child_cnt[parent_of[it.task_slot][3:0]]--;
                    parent_of[it.task_slot] = 5'h10;
                    child_cnt[it.task_slot] = '0;
                    busy[it.task_slot] = 1'b0;
                    for (int i = 0; i < 16; i++)
                        if (parent_of[i] == {1'b0, it.task_slot}) parent_of[i] = 5'h10;
                    found = -1;
                    for (int k = 0; k < count; k++)
                        if (found < 0 && ring[front + k[3:0]] == it.task_slot) found = k;
                    if (found >= 0) begin
                        for (int j = found; j + 1 < count; j++)
                            ring[front + j[3:0]] = ring[front + j[3:0] + 4'd1];
                        count--;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || s_axis_tready) begin
                if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
                    expected_results.push_back(predict(cmd_queue[0]));
                    s_axis_tdata <= {6'd0, cmd_queue.pop_front()};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            if (cfg_req != cfg_done && !i_cfg_valid) begin
                i_cfg_valid <= 1'b1;
                i_cfg_data <= cfg_value;
            end else if (i_cfg_valid && o_cfg_ready) begin
                i_cfg_valid <= 1'b0;
                cfg_done <= cfg_done + 1;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("[dependency_counting_task_queue] ERROR");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[70:0];
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.status != want.status || got.out_slot != want.out_slot
                        || got.out_payload != want.out_payload) begin
                    $display("%0t mismatch expected %0d/%0d/%h actual %0d/%0d/%h", $time,
                             want.status, want.out_slot, want.out_payload,
                             got.status, got.out_slot, got.out_payload);
                    errors++;
                end
            end
        end
    end

    function automatic t_cmd_item mk(t_cmd c, logic [63:0] p, logic [3:0] t, logic [3:0] q);
        t_cmd_item it;
        it.cmd = c;
        it.payload = p;
        it.task_slot = t;
        it.parent_slot = q;
        return it;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic drain();
        while (cmd_queue.size() > 0 || expected_results.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [3:0] v);
        drain();
        dep_limit = v;
        cfg_value = v;
        cfg_req++;
        while (cfg_done != cfg_req) @(posedge i_clk);
    endtask

    task automatic add_random(int n);
        t_cmd_item it;
        int c;
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(99);
            if (c < 30) it = mk(CMD_ENQ, rnd64(), 4'($urandom()), 4'($urandom()));
            else if (c < 55) it = mk(CMD_DEP, rnd64(), 4'($urandom()), 4'($urandom()));
            else if (c < 78) it = mk(CMD_DISP, rnd64(), 4'($urandom()), 4'($urandom()));
            else it = mk(CMD_CMPL, rnd64(), 4'($urandom()), 4'($urandom()));
            cmd_queue.push_back(it);
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++) begin
            pay_mem[i] = '0;
            child_cnt[i] = '0;
            parent_of[i] = 5'h10;
            ring[i] = '0;
        end
        busy = '0;
        front = '0;
        count = 0;
        dep_limit = LimitReset;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle = 19;
        recv_idle = 57;
        // directed: empty queue, unused slots, fill, links, limit, cycles
        cmd_queue.push_back(mk(CMD_DISP, '1, 4'd0, 4'd0));
        cmd_queue.push_back(mk(CMD_CMPL, '0, 4'd15, 4'd0));
        cmd_queue.push_back(mk(CMD_DEP, '0, 4'd0, 4'd15));
        for (int i = 0; i < 17; i++)
            cmd_queue.push_back(mk(CMD_ENQ, (i == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : rnd64(),
                                   4'd0, 4'd0));
        cmd_queue.push_back(mk(CMD_DEP, '0, 4'd1, 4'd1));
        cmd_queue.push_back(mk(CMD_DEP, '0, 4'd1, 4'd2));
        cmd_queue.push_back(mk(CMD_DEP, '0, 4'd2, 4'd3));
        cmd_queue.push_back(mk(CMD_DEP, '0, 4'd3, 4'd2));
        cmd_queue.push_back(mk(CMD_DISP, '0, 4'd0, 4'd0));
        cmd_queue.push_back(mk(CMD_CMPL, '0, 4'd2, 4'd0));
        add_random(280);
        write_limit(4'd0);
        cmd_queue.push_back(mk(CMD_DEP, '0, 4'd0, 4'd1));
        add_random(100);
        write_limit(4'd15);
        send_idle = 57;
        recv_idle = 19;
        add_random(200);
        write_limit(4'd1);
        add_random(100);
        write_limit(4'd2);
        send_idle = 0;
        recv_idle = 0;
        add_random(200);
        drain();
        if (errors == 0)
            $display("[dependency_counting_task_queue] OK");
        else
            $display("[dependency_counting_task_queue] ERROR");
        $finish;
    end
endmodule
